[rtl/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg: shared types and codes for the LIFO stack with search
// Operation and status codes, controller states and the cell shift command.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int WORD_W = 32;
   localparam int POS_W  = 7;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_SEARCH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_REPORT
   } state_type;

   // DOWN: take the word from the cell above (push)
   // UP:   take the word from the cell below (pop, rotate)
   typedef enum logic [1:0] {
      SH_HOLD,
      SH_DOWN,
      SH_UP
   } shift_type;

endpackage

[rtl/lss_cell.sv]
// ----------------------------------------------------------------------------
// lss_cell: one stack slot
// Holds a word and moves it to a neighbour on push, pop or rotate.
// ----------------------------------------------------------------------------
module lss_cell (
   input  logic                          clock,
   input  lss_pkg::shift_type            shift,
   input  logic [lss_pkg::WORD_W-1:0]    from_above,
   input  logic [lss_pkg::WORD_W-1:0]    from_below,
   output logic [lss_pkg::WORD_W-1:0]    word
);
   import lss_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      unique case (shift)
         SH_DOWN: word_in = from_above;
         SH_UP:   word_in = from_below;
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

[rtl/lss_ctrl.sv]
// ----------------------------------------------------------------------------
// lss_ctrl: operation sequencer
// Decodes operations, keeps the fill count, drives the cell chain and the
// output register; display and search rotate the whole chain once.
// ----------------------------------------------------------------------------
module lss_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [31:0]            rsp_data,
   output logic [6:0]                    rsp_position,
   output logic                          rsp_last,
   input  logic [lss_pkg::WORD_W-1:0]    top_word,
   output lss_pkg::shift_type            shift
);
   import lss_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] LAST_STEP = CW'(DEPTH - 1);

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     step_ff, step_in;
   logic              search_ff, search_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  hit_pos_ff, hit_pos_in;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [WORD_W-1:0] out_data_ff, out_data_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic              out_last_ff, out_last_in;

   logic   out_free;
   logic   accept;
   logic   live;
   logic   walk_go;
   op_type op;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign op        = op_type'(req_operation);
   assign live      = step_ff < count_ff;
   assign walk_go   = (state_ff == S_WALK) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && count_ff != '0 &&
                (op == OP_DISPLAY || op == OP_SEARCH)) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_go && step_ff == LAST_STEP) begin
               state_in = search_ff ? S_REPORT : S_IDLE;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      step_in       = step_ff;
      search_in     = search_ff;
      key_in        = key_ff;
      hit_in        = hit_ff;
      hit_pos_in    = hit_pos_ff;
      shift         = SH_HOLD;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_status_in = ST_OK;
               out_data_in   = '0;
               out_pos_in    = '0;
               out_last_in   = 1'b1;
               step_in       = '0;
               hit_in        = 1'b0;
               hit_pos_in    = '0;
               search_in     = (op == OP_SEARCH);
               key_in        = req_value;
               unique case (op)
                  OP_PUSH: begin
                     out_valid_in = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        out_status_in = ST_FULL;
                     end else begin
                        shift    = SH_DOWN;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     out_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        out_data_in = top_word;
                        shift       = SH_UP;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            if (walk_go) begin
               shift   = SH_UP;
               step_in = step_ff + CW'(1);
               if (!search_ff && live) begin
                  out_valid_in  = 1'b1;
                  out_status_in = ST_OK;
                  out_data_in   = top_word;
                  out_pos_in    = '0;
                  out_last_in   = (step_ff == count_ff - CW'(1));
               end
               if (search_ff && live && !hit_ff && top_word == key_ff) begin
                  hit_in     = 1'b1;
                  hit_pos_in = POS_W'(step_ff) + POS_W'(1);
               end
            end
         end
         S_REPORT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = hit_ff ? ST_OK : ST_MISS;
               out_data_in   = '0;
               out_pos_in    = hit_ff ? hit_pos_ff : '0;
               out_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      search_ff     <= search_in;
      key_ff        <= key_in;
      hit_ff        <= hit_in;
      hit_pos_ff    <= hit_pos_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_pos_ff    <= out_pos_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_last     = out_last_ff;

endmodule

[rtl/lifo_stack_with_search_top.sv]
// Push and pop give their response in the cycle after acceptance.
// Display walks the cell chain once, one word out per cycle for each filled
// cell while the consumer keeps up. Search walks it likewise, then reports.
// Throughput: one push/pop per cycle if the consumer keeps up; none during a walk.
// Reset: synchronous, active high; clears the fill count, the sequencer and
// the output valid. Cell contents are not reset.
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top: bounded LIFO with linear search
// A row of DEPTH cells, cell 0 holding the top of stack. Push shifts the row
// down, pop shifts it up; display and search rotate it through cell 0 and
// come back to the original order after DEPTH steps.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [6:0]         rsp_position,
   output logic               rsp_last
);
   import lss_pkg::*;

   // words[i] is the content of cell i; words[0] is the top
   logic [WORD_W-1:0] words [DEPTH];
   shift_type         shift;

   lss_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last),
      .top_word      (words[0]),
      .shift         (shift)
   );

   // cell chain: the pushed word enters at the top, the bottom wraps to the
   // top word so that an upward shift is a rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] above;
      logic [WORD_W-1:0] below;

      if (i == 0) begin : g_top
         assign above = req_value;
      end else begin : g_mid
         assign above = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_bot
         assign below = words[0];
      end else begin : g_up
         assign below = words[i+1];
      end

      lss_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .word       (words[i])
      );
   end

   // checks
   localparam int CW = $clog2(DEPTH + 1);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      u_ctrl.count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_walk_count_held : assert property (@(posedge clock) disable iff (reset)
      (u_ctrl.state_ff == S_WALK) |=> (u_ctrl.count_ff == $past(u_ctrl.count_ff)))
      else $error("fill count moved during a walk");

   a_full_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY)) |-> rsp_last)
      else $error("full or empty word not marked last");

   a_busy_no_ready : assert property (@(posedge clock) disable iff (reset)
      (u_ctrl.state_ff == S_WALK || u_ctrl.state_ff == S_REPORT) |-> !req_ready)
      else $error("input ready while walking");

endmodule
